[hdl/phr_pkg.sv]
// ----------------------------------------------------------------------------
// phr_pkg - shared types and codes of the polar histogram resampler
// item kinds, status codes, field widths and the packed grid cell
// ----------------------------------------------------------------------------
package phr_pkg;

   localparam int KIND_W = 3;
   localparam int ELEV_W = 5;
   localparam int AZIM_W = 6;
   localparam int VAL_W  = 16;
   localparam int STAT_W = 2;
   localparam int SUM_W  = VAL_W + 2;

   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DOWN  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UP    = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_WRONG_RES = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

   typedef struct packed {
      logic [VAL_W-1:0] age;
      logic [VAL_W-1:0] distance;
   } cell_type;

endpackage

[hdl/polar_histogram_resampler.sv]
// ----------------------------------------------------------------------------
// polar_histogram_resampler - polar grid of age / distance cells
// clears, writes and reads cells, and resamples the grid between full and
// half angular resolution with a small sequencer around one grid memory
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   csr_      in         csr_valid / csr_ready  csr_start_half_res
//   req_      in         req_valid / req_stall  kind, elev_index, azim_index,
//                                               age_in, dist_in
//   rsp_      out        rsp_valid / rsp_stall  status, age_out, dist_out,
//                                               half_res
//
// the single grid memory port (one access a cycle) carries every item: clear
//   sweeps all full grid cells, upsample reads and writes each full grid cell,
//   downsample reads four cells and writes their mean per half grid cell, then
//   zeroes every cell outside the half grid; writes and reads touch one cell
// after reset a clearing pass over all FULL_ROWS*FULL_COLS cells runs before the
//   first req transfer; csr writes are taken throughout
// one item at a time: req_stall is high from the transfer until the result
//   is in the rsp register; a stalled rsp only delays that last step
// ----------------------------------------------------------------------------
module polar_histogram_resampler #(
   parameter int FULL_ROWS = 30,
   parameter int FULL_COLS = 60
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_start_half_res,
   // request
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [phr_pkg::KIND_W-1:0]   req_kind,
   input  logic [phr_pkg::ELEV_W-1:0]   req_elev_index,
   input  logic [phr_pkg::AZIM_W-1:0]   req_azim_index,
   input  logic [phr_pkg::VAL_W-1:0]    req_age_in,
   input  logic [phr_pkg::VAL_W-1:0]    req_dist_in,
   // response
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [phr_pkg::STAT_W-1:0]   rsp_status,
   output logic [phr_pkg::VAL_W-1:0]    rsp_age_out,
   output logic [phr_pkg::VAL_W-1:0]    rsp_dist_out,
   output logic                         rsp_half_res
);
   import phr_pkg::*;

   localparam int HALF_ROWS = FULL_ROWS / 2;
   localparam int HALF_COLS = FULL_COLS / 2;
   localparam int CELLS     = FULL_ROWS * FULL_COLS;
   localparam int RW        = $clog2(FULL_ROWS);
   localparam int CW        = $clog2(FULL_COLS);
   localparam int AW        = $clog2(CELLS);
   // wide enough for every index field and every grid size
   localparam int CMP_W     = $clog2(FULL_ROWS + FULL_COLS + 64) + 1;

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_CELL_RD = 4'd2;
   localparam logic [3:0] S_CLR     = 4'd3;
   localparam logic [3:0] S_DS_RD   = 4'd4;
   localparam logic [3:0] S_DS_WR   = 4'd5;
   localparam logic [3:0] S_TRIM    = 4'd6;
   localparam logic [3:0] S_US_RD   = 4'd7;
   localparam logic [3:0] S_US_WR   = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // control state
   logic [3:0]        state_ff, state_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [1:0]        q_ff, q_in;
   logic              respond_ff, respond_in;
   logic              half_ff, half_in;
   logic              start_half_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // latched request
   logic [KIND_W-1:0] kind_ff;
   logic [ELEV_W-1:0] elev_ff;
   logic [AZIM_W-1:0] azim_ff;
   logic [VAL_W-1:0]  age_ff;
   logic [VAL_W-1:0]  dist_ff;

   // working result and mean accumulators
   logic [STAT_W-1:0] res_status_ff, res_status_in;
   logic [VAL_W-1:0]  res_age_ff, res_age_in;
   logic [VAL_W-1:0]  res_dist_ff, res_dist_in;
   logic [SUM_W-1:0]  sum_age_ff, sum_age_in;
   logic [SUM_W-1:0]  sum_dist_ff, sum_dist_in;

   // response register
   logic [STAT_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]  rsp_age_ff;
   logic [VAL_W-1:0]  rsp_dist_ff;
   logic              rsp_half_ff;
   logic              rsp_load;

   // memory port and the shared address unit
   logic [RW-1:0]     mul_row;
   logic [CW-1:0]     mul_col;
   logic [AW-1:0]     mem_addr;
   logic              mem_we, mem_re;
   cell_type          mem_wdata, mem_rdata;

   logic              req_xfer;
   logic              fwd_last, half_col_last, half_row_last;
   logic              in_range;
   logic [CMP_W-1:0]  rows_lim, cols_lim;
   logic [RW-1:0]     src_row, row_half;
   logic [CW-1:0]     src_col, col_half;
   logic [SUM_W-1:0]  mean_age, mean_dist;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   // a write during reset would be lost, so it is not offered then
   assign csr_ready = !reset;

   // raster walkers over the full and the half grid
   assign fwd_last      = (row_ff == RW'(FULL_ROWS - 1)) && (col_ff == CW'(FULL_COLS - 1));
   assign half_col_last = (col_ff == CW'(HALF_COLS - 1));
   assign half_row_last = (row_ff == RW'(HALF_ROWS - 1));

   // cell bounds at the current resolution
   assign rows_lim = half_ff ? CMP_W'(HALF_ROWS) : CMP_W'(FULL_ROWS);
   assign cols_lim = half_ff ? CMP_W'(HALF_COLS) : CMP_W'(FULL_COLS);
   assign in_range = (CMP_W'(elev_ff) < rows_lim) && (CMP_W'(azim_ff) < cols_lim);

   // upsample source, clamped onto the last half row / column
   assign row_half = row_ff >> 1;
   assign col_half = col_ff >> 1;
   assign src_row  = (row_half > RW'(HALF_ROWS - 1)) ? RW'(HALF_ROWS - 1) : row_half;
   assign src_col  = (col_half > CW'(HALF_COLS - 1)) ? CW'(HALF_COLS - 1) : col_half;

   // fourth term of the 2x2 sum lands in the write cycle
   assign mean_age  = sum_age_ff + SUM_W'(mem_rdata.age);
   assign mean_dist = sum_dist_ff + SUM_W'(mem_rdata.distance);

   // cell (r,c) lives at r*FULL_COLS+c at both resolutions
   assign mem_addr = AW'(mul_row) * AW'(FULL_COLS) + AW'(mul_col);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      q_in          = q_ff;
      respond_in    = respond_ff;
      half_in       = half_ff;
      res_status_in = res_status_ff;
      res_age_in    = res_age_ff;
      res_dist_in   = res_dist_ff;
      sum_age_in    = sum_age_ff;
      sum_dist_in   = sum_dist_ff;
      mul_row       = row_ff;
      mul_col       = col_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_wdata     = '0;
      rsp_load      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = STAT_OK;
            res_age_in    = '0;
            res_dist_in   = '0;
            state_in      = S_DONE;
            case (kind_ff)
               KIND_CLEAR: begin
                  half_in    = start_half_ff;
                  respond_in = 1'b1;
                  row_in     = '0;
                  col_in     = '0;
                  state_in   = S_CLR;
               end
               KIND_WRITE, KIND_READ: begin
                  if (!in_range) begin
                     res_status_in = STAT_RANGE;
                  end else begin
                     mul_row = RW'(elev_ff);
                     mul_col = CW'(azim_ff);
                     if (kind_ff == KIND_WRITE) begin
                        mem_we             = 1'b1;
                        mem_wdata.age      = age_ff;
                        mem_wdata.distance = dist_ff;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_CELL_RD;
                     end
                  end
               end
               KIND_DOWN: begin
                  if (half_ff) begin
                     res_status_in = STAT_WRONG_RES;
                  end else begin
                     row_in   = '0;
                     col_in   = '0;
                     q_in     = '0;
                     state_in = S_DS_RD;
                  end
               end
               KIND_UP: begin
                  if (!half_ff) begin
                     res_status_in = STAT_WRONG_RES;
                  end else begin
                     row_in   = RW'(FULL_ROWS - 1);
                     col_in   = CW'(FULL_COLS - 1);
                     state_in = S_US_RD;
                  end
               end
               default: begin
               end
            endcase
         end

         S_CELL_RD: begin
            res_age_in  = mem_rdata.age;
            res_dist_in = mem_rdata.distance;
            state_in    = S_DONE;
         end

         // zero sweep, after reset without a response
         S_CLR: begin
            mem_we = 1'b1;
            if (fwd_last) begin
               row_in   = '0;
               col_in   = '0;
               state_in = respond_ff ? S_DONE : S_IDLE;
            end else if (col_ff == CW'(FULL_COLS - 1)) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end

         // four reads of one 2x2 block, summed as the data returns
         S_DS_RD: begin
            mul_row = RW'({row_ff, q_ff[1]});
            mul_col = CW'({col_ff, q_ff[0]});
            mem_re  = 1'b1;
            if (q_ff == 2'd0) begin
               sum_age_in  = '0;
               sum_dist_in = '0;
            end else begin
               sum_age_in  = mean_age;
               sum_dist_in = mean_dist;
            end
            q_in = q_ff + 2'd1;
            if (q_ff == 2'd3) begin
               state_in = S_DS_WR;
            end
         end

         // in place: the mean never lands on a cell still to be read
         S_DS_WR: begin
            mem_we             = 1'b1;
            mem_wdata.age      = mean_age[SUM_W-1:2];
            mem_wdata.distance = mean_dist[SUM_W-1:2];
            state_in           = S_DS_RD;
            if (half_col_last) begin
               col_in = '0;
               if (half_row_last) begin
                  row_in   = '0;
                  state_in = S_TRIM;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end

         // zero every cell outside the half grid
         S_TRIM: begin
            mem_we = (row_ff >= RW'(HALF_ROWS)) || (col_ff >= CW'(HALF_COLS));
            if (fwd_last) begin
               row_in   = '0;
               col_in   = '0;
               half_in  = 1'b1;
               state_in = S_DONE;
            end else if (col_ff == CW'(FULL_COLS - 1)) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = col_ff + CW'(1);
            end
         end

         // reverse raster so each source is read before it is overwritten
         S_US_RD: begin
            mul_row  = src_row;
            mul_col  = src_col;
            mem_re   = 1'b1;
            state_in = S_US_WR;
         end

         S_US_WR: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            state_in  = S_US_RD;
            if (col_ff == '0) begin
               col_in = CW'(FULL_COLS - 1);
               if (row_ff == '0) begin
                  half_in  = 1'b0;
                  state_in = S_DONE;
               end else begin
                  row_in = row_ff - RW'(1);
               end
            end else begin
               col_in = col_ff - CW'(1);
            end
         end

         // wait for the response register to free up
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         row_ff        <= '0;
         col_ff        <= '0;
         q_ff          <= '0;
         respond_ff    <= 1'b0;
         half_ff       <= 1'b0;
         start_half_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         q_ff         <= q_in;
         respond_ff   <= respond_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            start_half_ff <= csr_start_half_res;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff <= req_kind;
         elev_ff <= req_elev_index;
         azim_ff <= req_azim_index;
         age_ff  <= req_age_in;
         dist_ff <= req_dist_in;
      end
      res_status_ff <= res_status_in;
      res_age_ff    <= res_age_in;
      res_dist_ff   <= res_dist_in;
      sum_age_ff    <= sum_age_in;
      sum_dist_ff   <= sum_dist_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_age_ff    <= res_age_ff;
         rsp_dist_ff   <= res_dist_ff;
         rsp_half_ff   <= half_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_age_out  = rsp_age_ff;
   assign rsp_dist_out = rsp_dist_ff;
   assign rsp_half_res = rsp_half_ff;

   phr_grid_mem #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_grid (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // a response appears only out of the completion state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside completion");

   // the grid is never written while idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("grid write while idle");

   // a finished downsample leaves the grid at half resolution
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRIM && fwd_last) |=> half_ff)
      else $error("downsample did not set half resolution");

   // a finished upsample leaves the grid at full resolution
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_US_WR && row_ff == '0 && col_ff == '0) |=> !half_ff)
      else $error("upsample did not set full resolution");

   // only defined status codes are reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == STAT_OK || rsp_status_ff == STAT_WRONG_RES ||
                        rsp_status_ff == STAT_RANGE))
      else $error("undefined status code");

endmodule

[hdl/phr_grid_mem.sv]
// ----------------------------------------------------------------------------
// phr_grid_mem - single port grid memory
// one access a cycle, write or read, read data registered
// ----------------------------------------------------------------------------
module phr_grid_mem #(
   parameter int DEPTH = 1800,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [AW-1:0]     addr,
   input  phr_pkg::cell_type wdata,
   output phr_pkg::cell_type rdata
);
   import phr_pkg::*;

   cell_type mem_ff [DEPTH];
   cell_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
